// ----- hw/rtl/srs_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srs_pkg
// Shared types and constants of the sequential router / selector.
// ----------------------------------------------------------------------------
package srs_pkg;

  localparam int SLOTS      = 8;   // sample slots carried on the channels
  localparam int SLOT_BITS  = 16;  // width of one sample slot
  localparam int STEP_BITS  = 4;   // signed step, -1 while idle
  localparam int LAST_BITS  = 3;   // last step index after limiting
  localparam int REG_BITS   = 4;   // widest configuration register
  localparam int INDEX_BITS = 2;   // register index width

  typedef logic signed [STEP_BITS-1:0] step_t;

  localparam step_t STEP_IDLE = -4'sd1;

  // register indexes
  localparam logic [INDEX_BITS-1:0] REG_ROUTER_LAST   = 2'd0;
  localparam logic [INDEX_BITS-1:0] REG_SELECTOR_LAST = 2'd1;
  localparam logic [INDEX_BITS-1:0] REG_HOLD_MODE     = 2'd2;
  localparam logic [INDEX_BITS-1:0] REG_NORMAL_MODE   = 2'd3;

  // hold modes
  localparam logic [1:0] HOLD_TRACK_HOLD  = 2'd0;
  localparam logic [1:0] HOLD_TRACK_ONLY  = 2'd1;
  localparam logic [1:0] HOLD_SAMPLE_HOLD = 2'd2;

  // normal values for an unpatched receive
  localparam logic [1:0] NORM_SEND     = 2'd0;
  localparam logic [1:0] NORM_ZERO     = 2'd1;
  localparam logic [1:0] NORM_ASSOC    = 2'd2;
  localparam logic [1:0] NORM_SELECTED = 2'd3;

  typedef struct packed {
    logic        router_clock;
    logic        selector_clock;
    logic        selector_clock_present;
    logic        router_reset;
    logic        selector_reset;
    logic        selector_reset_present;
    logic [15:0] send_sample;
    logic [7:0]  receive_present_mask;
    logic [63:0] receives_low_four;
    logic [63:0] receives_high_four;
  } tick_t;

  typedef struct packed {
    logic [63:0] sends_low_four;
    logic [63:0] sends_high_four;
    logic [15:0] selector_out;
    step_t       router_position;
    step_t       selector_position;
  } result_t;

  // control of one step counter
  typedef struct packed {
    logic                 en;     // tick transfer this cycle
    logic                 clear;  // reset gate high
    logic                 rise;   // clock gate rising edge
    logic [LAST_BITS-1:0] last;   // last step index, already limited
  } step_ctl_t;

endpackage
`default_nettype wire

// ----- hw/rtl/srs_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srs_tick_if / srs_result_if
// Valid/ready channels for input ticks and result items.
// ----------------------------------------------------------------------------
interface srs_tick_if;
  logic            valid;
  logic            ready;
  srs_pkg::tick_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface srs_result_if;
  logic             valid;
  logic             ready;
  srs_pkg::result_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/sequential_router_selector.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sequential_router_selector
// Eight-slot sequential switch: routes the send sample to the router step
// output and picks the receive at the selector step, one tick per transfer.
// ----------------------------------------------------------------------------
//
//  channel    dir   handshake      payload
//  ---------  ----  -------------  ----------------------------------------
//  ticks      in    valid/ready    gates, send sample, receive mask/samples
//  results    out   valid/ready    router outputs, selector out, positions
//  wr_*       in    wr_en only     reg_index, wr_data (4 bits)
//
//  one tick per cycle while results.ready is high: gate decode, step advance
//  and output muxing are combinational from the tick transfer into the result register
//  reset (rst, synchronous) idles both steps, clears held outputs and
//  restores the register defaults
//  a waiting result does not block input as long as results.ready is high;
//  ticks.ready drops only while the result register is full and stalled
//
module sequential_router_selector #(
  parameter int CHANNELS    = 8,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  srs_tick_if.sink                               ticks,
  srs_result_if.source                           results,
  input  wire logic                              wr_en,
  input  wire logic [srs_pkg::INDEX_BITS-1:0]    reg_index,
  input  wire logic [srs_pkg::REG_BITS-1:0]      wr_data
);

  localparam int SLOT_W = srs_pkg::SLOT_BITS;
  localparam int STEP_W = srs_pkg::STEP_BITS;
  localparam int LAST_W = srs_pkg::LAST_BITS;
  localparam logic [LAST_W-1:0] LAST_MAX = LAST_W'(CHANNELS - 1);

  // sign-extend a sample to its slot
  function automatic logic [SLOT_W-1:0] ext(input logic signed [SAMPLE_BITS-1:0] v);
    return SLOT_W'(v);
  endfunction

  // configuration registers
  logic [LAST_W-1:0]   router_last;
  logic [3:0]          selector_last;
  logic [1:0]          hold_mode;
  logic [1:0]          normal_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      router_last   <= 3'd7;
      selector_last <= 4'd8;
      hold_mode     <= srs_pkg::HOLD_TRACK_ONLY;
      normal_mode   <= srs_pkg::NORM_SEND;
    end else if (wr_en) begin
      unique case (reg_index)
        srs_pkg::REG_ROUTER_LAST:   router_last   <= wr_data[LAST_W-1:0];
        srs_pkg::REG_SELECTOR_LAST: selector_last <= wr_data;
        srs_pkg::REG_HOLD_MODE:     hold_mode     <= wr_data[1:0];
        srs_pkg::REG_NORMAL_MODE:   normal_mode   <= wr_data[1:0];
        default: ;
      endcase
    end
  end

  // handshake: result register frees up when taken
  logic accept;
  assign ticks.ready = !results.valid || results.ready;
  assign accept      = ticks.valid && ticks.ready;

  // gate decode
  logic prev_rclk, prev_sclk;
  logic rclk, sclk, rrst, srst, redge, sedge;

  assign rclk  = ticks.data.router_clock;
  assign sclk  = ticks.data.selector_clock_present ? ticks.data.selector_clock : rclk;
  assign rrst  = ticks.data.router_reset;
  assign srst  = ticks.data.selector_reset_present ? ticks.data.selector_reset : rrst;
  assign redge = rclk && !prev_rclk;
  assign sedge = sclk && !prev_sclk;

  // step lengths, limited to the channel count; selector values above 7 follow the router
  logic [LAST_W-1:0] rlast, slast;
  assign rlast = (router_last > LAST_MAX) ? LAST_MAX : router_last;
  always_comb begin
    if (selector_last > 4'd7) begin
      slast = rlast;
    end else if (selector_last[LAST_W-1:0] > LAST_MAX) begin
      slast = LAST_MAX;
    end else begin
      slast = selector_last[LAST_W-1:0];
    end
  end

  // step counters
  srs_pkg::step_ctl_t rctl, sctl;
  srs_pkg::step_t     rstep_next, sstep_next;

  assign rctl = '{en: accept, clear: rrst, rise: redge, last: rlast};
  assign sctl = '{en: accept, clear: srst, rise: sedge, last: slast};

  srs_step u_router_step (
    .clk       (clk),
    .rst       (rst),
    .ctl       (rctl),
    .step_next (rstep_next)
  );

  srs_step u_selector_step (
    .clk       (clk),
    .rst       (rst),
    .ctl       (sctl),
    .step_next (sstep_next)
  );

  // router outputs
  logic [SAMPLE_BITS-1:0] send_s;
  logic [SAMPLE_BITS-1:0] held      [CHANNELS];
  logic [SAMPLE_BITS-1:0] held_next [CHANNELS];
  logic                   sample_now;

  assign send_s     = ticks.data.send_sample[SAMPLE_BITS-1:0];
  // sample-and-hold only takes a new value on a router advance
  assign sample_now = (hold_mode != srs_pkg::HOLD_SAMPLE_HOLD) || (!rrst && redge);

  always_comb begin
    for (int i = 0; i < CHANNELS; i++) begin
      logic at;
      at = (rstep_next == STEP_W'(i));
      held_next[i] = held[i];
      case (hold_mode)
        srs_pkg::HOLD_TRACK_HOLD: begin
          if (at) held_next[i] = send_s;
        end
        srs_pkg::HOLD_SAMPLE_HOLD: begin
          if (at && sample_now) held_next[i] = send_s;
        end
        default: begin
          // track only: unselected outputs go to zero
          held_next[i] = at ? send_s : '0;
        end
      endcase
    end
  end

  // receive slots
  logic [SLOT_W-1:0] rx_slot [srs_pkg::SLOTS];
  always_comb begin
    for (int j = 0; j < srs_pkg::SLOTS / 2; j++) begin
      rx_slot[j]                     = ticks.data.receives_low_four[j*SLOT_W +: SLOT_W];
      rx_slot[j + srs_pkg::SLOTS/2]  = ticks.data.receives_high_four[j*SLOT_W +: SLOT_W];
    end
  end

  // selector lane pick
  logic [SAMPLE_BITS-1:0] sel_rx, sel_held, route_held, sel_val;
  logic                   sel_present, sel_active;
  logic [SAMPLE_BITS-1:0] last_sel;

  always_comb begin
    sel_rx      = '0;
    sel_held    = '0;
    route_held  = '0;  // idle router reads as zero
    sel_present = 1'b0;
    for (int i = 0; i < CHANNELS; i++) begin
      if (sstep_next == STEP_W'(i)) begin
        sel_rx      = rx_slot[i][SAMPLE_BITS-1:0];
        sel_held    = held_next[i];
        sel_present = ticks.data.receive_present_mask[i];
      end
      if (rstep_next == STEP_W'(i)) begin
        route_held = held_next[i];
      end
    end
  end

  assign sel_active = !sstep_next[STEP_W-1];

  always_comb begin
    if (sel_present) begin
      sel_val = sel_rx;
    end else begin
      case (normal_mode)
        srs_pkg::NORM_SEND:     sel_val = send_s;
        srs_pkg::NORM_ZERO:     sel_val = '0;
        srs_pkg::NORM_ASSOC:    sel_val = sel_held;
        srs_pkg::NORM_SELECTED: sel_val = route_held;
        default:                sel_val = '0;
      endcase
    end
  end

  logic [SAMPLE_BITS-1:0] last_sel_next;
  assign last_sel_next = sel_active ? sel_val : last_sel;

  // state update on each tick transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_rclk <= 1'b0;
      prev_sclk <= 1'b0;
      last_sel  <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        held[i] <= '0;
      end
    end else if (accept) begin
      prev_rclk <= rclk;
      prev_sclk <= sclk;
      last_sel  <= last_sel_next;
      for (int i = 0; i < CHANNELS; i++) begin
        held[i] <= held_next[i];
      end
    end
  end

  // result slots, unused channels read zero
  logic [SLOT_W-1:0] out_slot [srs_pkg::SLOTS];
  for (genvar j = 0; j < srs_pkg::SLOTS; j++) begin : g_slot
    if (j < CHANNELS) begin : g_used
      assign out_slot[j] = ext(held_next[j]);
    end else begin : g_unused
      assign out_slot[j] = '0;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (accept) begin
      results.valid <= 1'b1;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      results.data.sends_low_four    <= {out_slot[3], out_slot[2], out_slot[1], out_slot[0]};
      results.data.sends_high_four   <= {out_slot[7], out_slot[6], out_slot[5], out_slot[4]};
      results.data.selector_out      <= ext(last_sel_next);
      results.data.router_position   <= rstep_next;
      results.data.selector_position <= sstep_next;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/srs_step.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srs_step
// Step counter: wraps after the last step, idles at -1 while cleared.
// ----------------------------------------------------------------------------
module srs_step (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire srs_pkg::step_ctl_t ctl,
  output srs_pkg::step_t          step_next
);

  srs_pkg::step_t step;
  srs_pkg::step_t last_s;

  assign last_s = srs_pkg::step_t'({1'b0, ctl.last});

  always_comb begin
    step_next = step;
    if (ctl.clear) begin
      step_next = srs_pkg::STEP_IDLE;
    end else if (ctl.rise) begin
      if (step < last_s) begin
        step_next = step + 4'sd1;
      end else begin
        step_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= srs_pkg::STEP_IDLE;
    end else if (ctl.en) begin
      step <= step_next;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/srs_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srs_checker
// Port-level checks of the sequential router / selector, bound to the top.
// ----------------------------------------------------------------------------
module srs_checker (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             in_valid,
  input wire logic             in_ready,
  input wire srs_pkg::tick_t   in_data,
  input wire logic             out_valid,
  input wire logic             out_ready,
  input wire srs_pkg::result_t out_data
);

  // a result stalled on the output keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // every tick transfer yields a result on the next cycle
  a_tick_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("tick transfer without result");

  // router reset gate idles the router step
  a_router_idle: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_data.router_reset |=> out_data.router_position == -4'sd1)
    else $error("router not idle after reset gate");

  // input is only stalled by a full, stalled result register
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without cause");

  // positions never go below idle (-1)
  a_positions: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.router_position >= -4'sd1 && out_data.selector_position >= -4'sd1)
    else $error("step position out of range");

endmodule

bind sequential_router_selector srs_checker u_srs_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (ticks.valid),
  .in_ready  (ticks.ready),
  .in_data   (ticks.data),
  .out_valid (results.valid),
  .out_ready (results.ready),
  .out_data  (results.data)
);
`default_nettype wire
